>>> sv/buffer_pool_queue_manager_defines.svh
// assertion macros for the buffer pool queue manager
// no dependencies; taken in by include where assertions are written
`ifndef BUFFER_POOL_QUEUE_MANAGER_DEFINES_SVH
`define BUFFER_POOL_QUEUE_MANAGER_DEFINES_SVH
`ifndef SYNTHESIS
// condition implies consequence in the same cycle
`define BPQM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bpqm: same-cycle check failed");
// condition implies consequence in the next cycle
`define BPQM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bpqm: next-cycle check failed");
`else
`define BPQM_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define BPQM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> sv/bpqm_pkg.sv
// shared types and constants of the buffer pool queue manager
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package bpqm_pkg;

	localparam int ID_W   = 4;
	localparam int LEN_W  = 16;
	localparam int KIND_W = 3;
	localparam int CNT_OUT_W = 5;
	localparam int ACT_W  = 5;
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	// request kinds
	localparam logic [KIND_W-1:0] KIND_ALLOC   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd1;
	localparam logic [KIND_W-1:0] KIND_WRITE   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_PUSH    = 3'd3;
	localparam logic [KIND_W-1:0] KIND_PEEK    = 3'd4;
	localparam logic [KIND_W-1:0] KIND_POP     = 3'd5;
	localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd6;

	// register select bit value within paddr
	localparam logic REG_BUFFER_SIZE    = 1'b0;
	localparam logic REG_ACTIVE_BUFFERS = 1'b1;

	localparam logic [LEN_W-1:0] BUFFER_SIZE_RST    = 16'd256;
	localparam logic [ACT_W-1:0] ACTIVE_BUFFERS_RST = 5'd16;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ID_W-1:0]   buffer_id;
		logic [ID_W-1:0]   position;
		logic [LEN_W-1:0]  data_length;
		logic [LEN_W-1:0]  write_offset;
	} req_t;

	typedef struct packed {
		logic                 found;
		logic [ID_W-1:0]      result_id;
		logic [LEN_W-1:0]     result_length;
		logic [CNT_OUT_W-1:0] pending_count;
	} rsp_t;

endpackage
`default_nettype wire

>>> sv/bpqm_if.sv
// request and response channels of the buffer pool queue manager
// depends on bpqm_pkg
`timescale 1ns / 1ps
`default_nettype none
interface bpqm_req_if;
	import bpqm_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface bpqm_rsp_if;
	import bpqm_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> sv/bpqm_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module bpqm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port, holds its data when idle
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

>>> sv/buffer_pool_queue_manager.sv
// A request reads the length and pending-slot rams in idle, runs in exec, and a peek
// that finds an entry also passes the peek state. A new request is taken only in idle
// with the skid register free, so only one request is in flight at a time.
// A response waiting on the output is parted from the core by a skid register.
// Reset: buffers empty and free, stored lengths read as 0, pending FIFO empty,
// buffer_size 256, active_buffers 16; the slot ram is not cleared and needs no pass.
// top level: marks, length ram, pending FIFO ram, apb registers
// depends on bpqm_pkg, bpqm_if, bpqm_ram and the defines header
`timescale 1ns / 1ps
`default_nettype none
`include "buffer_pool_queue_manager_defines.svh"
module buffer_pool_queue_manager #(
	parameter int NUM_BUFFERS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [bpqm_pkg::APB_AW-1:0]  paddr,
	input  wire logic [bpqm_pkg::APB_DW-1:0]  pwdata,
	output logic      [bpqm_pkg::APB_DW-1:0]  prdata,
	output logic                              pready,
	bpqm_req_if.sink                          req,
	bpqm_rsp_if.source                        rsp
);
	import bpqm_pkg::*;

	localparam int POOL   = (NUM_BUFFERS < 16) ? NUM_BUFFERS : 16;
	localparam int PW     = $clog2(POOL);
	localparam int SLOT_W = $clog2(NUM_BUFFERS);
	localparam int CNT_W  = $clog2(NUM_BUFFERS + 1);
	localparam int SUM_W  = ((SLOT_W > ID_W) ? SLOT_W : ID_W) + 1;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_PEEK = 3'b100
	} state_t;

	state_t state_q, state_d;

	logic [LEN_W-1:0] size_q;
	logic [ACT_W-1:0] active_q;

	logic [POOL-1:0] empty_q, empty_d;
	logic [POOL-1:0] busy_q, busy_d;
	logic [POOL-1:0] lvld_q, lvld_d;
	logic [SLOT_W-1:0] head_q, head_d;
	logic [CNT_W-1:0]  fill_q, fill_d;

	req_t req_s1;
	logic len_hit_s1;

	rsp_t res;
	logic res_fire;
	rsp_t out_q, skid_q;
	logic out_vld_q, skid_vld_q;

	logic              len_we, len_re;
	logic [PW-1:0]     len_waddr, len_raddr;
	logic [LEN_W-1:0]  len_wdata, len_rdata;
	logic              slot_we, slot_re;
	logic [SLOT_W-1:0] slot_waddr, slot_raddr;
	logic [ID_W-1:0]   slot_rdata;

	logic              req_fire;
	logic [ACT_W-1:0]  usable;
	logic              id_ok, push_ok, peek_ok;
	logic [SUM_W-1:0]  peek_sum, tail_sum;
	logic [SLOT_W-1:0] peek_addr, tail_addr;
	logic [LEN_W:0]    wr_end;
	logic [LEN_W-1:0]  wr_len;
	logic [POOL-1:0]   alloc_cand;
	logic              alloc_hit;
	logic [PW-1:0]     alloc_idx;
	logic [LEN_W-1:0]  stored_len;
	logic [CNT_W+CNT_OUT_W-1:0] fill_ext;
	logic              cfg_wr;

	// apb register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_ACTIVE_BUFFERS) ? APB_DW'(active_q) : APB_DW'(size_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q   <= BUFFER_SIZE_RST;
			active_q <= ACTIVE_BUFFERS_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_ACTIVE_BUFFERS) begin
				active_q <= pwdata[ACT_W-1:0];
			end else begin
				size_q <= pwdata[LEN_W-1:0];
			end
		end
	end

	// request handshake: one request in flight, skid must be free
	assign req.ready = (state_q == S_IDLE) && !skid_vld_q;
	assign req_fire  = req.valid && req.ready;

	// usable buffer count and id check
	always_comb begin
		if (active_q > ACT_W'(POOL)) begin
			usable = ACT_W'(POOL);
		end else begin
			usable = active_q;
		end
	end
	assign id_ok   = ACT_W'(req_s1.buffer_id) < usable;
	assign push_ok = id_ok && (fill_q != CNT_W'(NUM_BUFFERS));
	assign peek_ok = SUM_W'(req_s1.position) < SUM_W'(fill_q);

	// fifo slot addresses, wrapped modulo the fifo depth
	assign peek_sum = SUM_W'(head_q) + SUM_W'(req.data.position);
	assign tail_sum = SUM_W'(head_q) + SUM_W'(fill_q);
	assign peek_addr = (peek_sum >= SUM_W'(NUM_BUFFERS)) ?
		SLOT_W'(peek_sum - SUM_W'(NUM_BUFFERS)) : SLOT_W'(peek_sum);
	assign tail_addr = (tail_sum >= SUM_W'(NUM_BUFFERS)) ?
		SLOT_W'(tail_sum - SUM_W'(NUM_BUFFERS)) : SLOT_W'(tail_sum);

	// write length clamp to room left in the buffer
	assign wr_end = {1'b0, req_s1.data_length} + {1'b0, req_s1.write_offset};
	always_comb begin
		if (wr_end > {1'b0, size_q}) begin
			wr_len = (req_s1.write_offset >= size_q) ? '0 : size_q - req_s1.write_offset;
		end else begin
			wr_len = req_s1.data_length;
		end
	end

	// lowest free buffer search
	always_comb begin
		alloc_hit = 1'b0;
		alloc_idx = '0;
		for (int i = 0; i < POOL; i++) begin
			alloc_cand[i] = empty_q[i] && !busy_q[i] && (ACT_W'(i) < usable);
		end
		for (int i = POOL - 1; i >= 0; i--) begin
			if (alloc_cand[i]) begin
				alloc_hit = 1'b1;
				alloc_idx = PW'(i);
			end
		end
	end

	assign stored_len = len_hit_s1 ? len_rdata : '0;

	// sequencer: read in idle, modify and write back in exec, peek result in peek
	always_comb begin
		state_d    = state_q;
		empty_d    = empty_q;
		busy_d     = busy_q;
		lvld_d     = lvld_q;
		head_d     = head_q;
		fill_d     = fill_q;
		res        = '0;
		res_fire   = 1'b0;
		len_re     = 1'b0;
		len_raddr  = req.data.buffer_id[PW-1:0];
		len_we     = 1'b0;
		len_waddr  = req_s1.buffer_id[PW-1:0];
		len_wdata  = wr_len;
		slot_re    = 1'b0;
		slot_raddr = head_q;
		slot_we    = 1'b0;
		slot_waddr = tail_addr;
		case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					state_d = S_EXEC;
					len_re  = 1'b1;
					slot_re = 1'b1;
					if (req.data.kind == KIND_PEEK) begin
						slot_raddr = peek_addr;
					end
				end
			end
			S_EXEC: begin
				state_d  = S_IDLE;
				res_fire = 1'b1;
				case (req_s1.kind)
					KIND_ALLOC: begin
						if (alloc_hit) begin
							busy_d[alloc_idx] = 1'b1;
							res.found     = 1'b1;
							res.result_id = ID_W'(alloc_idx);
						end
					end
					KIND_RELEASE: begin
						if (id_ok) begin
							busy_d[req_s1.buffer_id[PW-1:0]] = 1'b0;
						end
					end
					KIND_WRITE: begin
						if (id_ok && (req_s1.data_length != '0)) begin
							len_we = 1'b1;
							lvld_d[req_s1.buffer_id[PW-1:0]] = 1'b1;
							res.result_length = wr_len;
						end
					end
					KIND_PUSH: begin
						if (push_ok) begin
							empty_d[req_s1.buffer_id[PW-1:0]] = 1'b0;
							busy_d[req_s1.buffer_id[PW-1:0]]  = 1'b0;
							slot_we = 1'b1;
							fill_d  = fill_q + 1'b1;
							res.found         = 1'b1;
							res.result_id     = req_s1.buffer_id;
							res.result_length = stored_len;
						end
					end
					KIND_PEEK: begin
						// second read: length of the buffer found in the slot
						if (peek_ok) begin
							res_fire  = 1'b0;
							state_d   = S_PEEK;
							len_re    = 1'b1;
							len_raddr = slot_rdata[PW-1:0];
						end
					end
					KIND_POP: begin
						if (fill_q != '0) begin
							empty_d[slot_rdata[PW-1:0]] = 1'b1;
							head_d = (head_q == SLOT_W'(NUM_BUFFERS - 1)) ? '0 : head_q + 1'b1;
							fill_d = fill_q - 1'b1;
						end
					end
					KIND_CLEAR: begin
						empty_d = '1;
						busy_d  = '0;
						lvld_d  = '0;
						head_d  = '0;
						fill_d  = '0;
					end
					default: begin
					end
				endcase
			end
			S_PEEK: begin
				state_d  = S_IDLE;
				res_fire = 1'b1;
				res.found         = 1'b1;
				res.result_id     = slot_rdata;
				res.result_length = stored_len;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		fill_ext = (CNT_W + CNT_OUT_W)'(fill_d);
		res.pending_count = fill_ext[CNT_OUT_W-1:0];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			empty_q <= '1;
			busy_q  <= '0;
			lvld_q  <= '0;
			head_q  <= '0;
			fill_q  <= '0;
		end else begin
			state_q <= state_d;
			empty_q <= empty_d;
			busy_q  <= busy_d;
			lvld_q  <= lvld_d;
			head_q  <= head_d;
			fill_q  <= fill_d;
		end
	end

	// request capture and length valid bit alongside the ram read
	always_ff @(posedge clk) begin
		if (req_fire) begin
			req_s1 <= req.data;
		end
		if (len_re) begin
			len_hit_s1 <= lvld_q[len_raddr];
		end
	end

	// output register with skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || rsp.ready) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= res_fire;
			end
		end else if (res_fire) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || rsp.ready) begin
			out_q <= skid_vld_q ? skid_q : res;
		end else if (res_fire) begin
			skid_q <= res;
		end
	end

	assign rsp.valid = out_vld_q;
	assign rsp.data  = out_q;

	// stored lengths per buffer
	bpqm_ram #(
		.WIDTH (LEN_W),
		.DEPTH (POOL)
	) u_len_ram (
		.clk   (clk),
		.we    (len_we),
		.waddr (len_waddr),
		.wdata (len_wdata),
		.re    (len_re),
		.raddr (len_raddr),
		.rdata (len_rdata)
	);

	// pending fifo slots
	bpqm_ram #(
		.WIDTH (ID_W),
		.DEPTH (NUM_BUFFERS)
	) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (req_s1.buffer_id),
		.re    (slot_re),
		.raddr (slot_raddr),
		.rdata (slot_rdata)
	);

	// checks
	`BPQM_ASSERT_SAME(a_fill_bound, clk, arst_n, 1'b1, fill_q <= CNT_W'(NUM_BUFFERS))
	`BPQM_ASSERT_SAME(a_skid_behind_out, clk, arst_n, skid_vld_q, out_vld_q)
	`BPQM_ASSERT_NEXT(a_accept_exec, clk, arst_n, req_fire, state_q == S_EXEC)
	`BPQM_ASSERT_NEXT(a_push_grows, clk, arst_n, (state_q == S_EXEC) && (req_s1.kind == KIND_PUSH) && push_ok, fill_q == $past(fill_q) + 1'b1)

endmodule
`default_nettype wire
